/* rtl/lzwd_pkg.sv */
package lzwd_pkg;

  localparam int CODE_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 24;

  localparam int DICT_ENTRIES_DEF = 4096;
  localparam int STACK_DEPTH_DEF  = 63;

  localparam logic [CODE_W-1:0] CODE_WIDTH_STEP  = CODE_W'(3);
  localparam logic [CODE_W-1:0] CODE_FIRST_BYTE  = CODE_W'(4);
  localparam logic [CODE_W-1:0] CODE_FIRST_ENTRY = CODE_W'(260);
  localparam logic [CODE_W-1:0] CODE_NONE        = CODE_W'(0);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_EMIT_FIRST,
    ST_EMIT_STACK,
    ST_ERROR
  } lzwd_state_t;

endpackage

/* rtl/lzwd_if.sv */
interface lzwd_in_if import lzwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code;

  modport source (output valid, output code, input ready);
  modport sink   (input valid, input code, output ready);
endinterface

interface lzwd_out_if import lzwd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               last_of_run;
  logic               corrupt;
  logic [TOTAL_W-1:0] total_count;

  modport source (output valid, output out_byte, output last_of_run, output corrupt,
                  output total_count, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input corrupt,
                  input total_count, output ready);
endinterface

/* rtl/lzwd_dict_ram.sv */
module lzwd_dict_ram import lzwd_pkg::*; #(
  parameter int ENTRIES = DICT_ENTRIES_DEF,
  parameter int AW      = $clog2(DICT_ENTRIES_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [AW-1:0]     wprefix,
  input  logic [BYTE_W-1:0] wsuffix,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [AW-1:0]     rprefix,
  output logic [BYTE_W-1:0] rsuffix
);

  // prefix link and suffix byte share one word
  logic [AW+BYTE_W-1:0] mem [ENTRIES];
  logic [AW+BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wprefix, wsuffix};
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rprefix = rdata_r[AW+BYTE_W-1:BYTE_W];
  assign rsuffix = rdata_r[BYTE_W-1:0];

endmodule

/* rtl/lzwd_stack_ram.sv */
module lzwd_stack_ram import lzwd_pkg::*; #(
  parameter int DEPTH = STACK_DEPTH_DEF,
  parameter int AW    = $clog2(STACK_DEPTH_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lzw_code_decoder_top.sv */
// First byte: follows acceptance and a walk of L prefix links (one dictionary read per
//   link, one check state per node). The next code is taken once D more bytes (L, or
//   L + 1 for KwKwK) are registered for output, which output stalls can hold back. A code
//   rejected at intake goes to the error state; width steps and codes after a stop drop in idle.
// Reset: rst_n is synchronous, active low; it empties the dictionary (fill count back to
//   260), clears the byte total and the stop flag. No memory clearing pass is needed.
module lzw_code_decoder_top import lzwd_pkg::*; #(
  parameter int DICT_ENTRIES = DICT_ENTRIES_DEF,
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lzwd_in_if.sink     in_chan,
  lzwd_out_if.source  out_chan
);

  localparam int AW  = $clog2(DICT_ENTRIES);       // dictionary index
  localparam int FW  = $clog2(DICT_ENTRIES + 1);   // fill count, holds DICT_ENTRIES
  localparam int SW  = $clog2(STACK_DEPTH);        // stack index
  localparam int DW  = $clog2(STACK_DEPTH + 1);    // stack depth, holds STACK_DEPTH
  localparam int CW1 = CODE_W + 1;                 // compare width for code vs counts

  // control state
  lzwd_state_t        state_r, state_nxt;
  logic               stopped_r, stopped_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [CODE_W-1:0]  prev_r, prev_nxt;
  logic [BYTE_W-1:0]  prev_first_r, prev_first_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  // per-code working registers
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic               unknown_r, unknown_nxt;
  logic [CODE_W-1:0]  node_r, node_nxt;
  logic [DW-1:0]      depth_r, depth_nxt;
  logic [SW-1:0]      idx_r, idx_nxt;
  logic [BYTE_W-1:0]  first_r, first_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_corrupt_r, out_corrupt_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;

  // memory ports
  logic               dict_we, dict_re;
  logic [AW-1:0]      dict_waddr, dict_wprefix, dict_raddr, dict_rprefix;
  logic [BYTE_W-1:0]  dict_wsuffix, dict_rsuffix;
  logic               stk_we, stk_re;
  logic [SW-1:0]      stk_waddr, stk_raddr;
  logic [BYTE_W-1:0]  stk_wdata, stk_rdata;

  // decode helpers
  logic               accept;
  logic               out_free;
  logic               code_unknown;
  logic               fill_full;
  logic               node_is_entry;
  logic               node_bad_byte;
  logic               walk_overflow;
  logic               can_add;
  logic [TOTAL_W-1:0] total_inc;

  lzwd_dict_ram #(
    .ENTRIES (DICT_ENTRIES),
    .AW      (AW)
  ) u_dict (
    .clk     (clk),
    .we      (dict_we),
    .waddr   (dict_waddr),
    .wprefix (dict_wprefix),
    .wsuffix (dict_wsuffix),
    .re      (dict_re),
    .raddr   (dict_raddr),
    .rprefix (dict_rprefix),
    .rsuffix (dict_rsuffix)
  );

  lzwd_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (SW)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // One request at a time: take a code only when the walker is idle. The output
  // register lets the next code start while the last byte still waits downstream.
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign code_unknown  = (CW1'(in_chan.code) >= CW1'(fill_r));
  assign fill_full     = (fill_r >= FW'(DICT_ENTRIES));
  assign node_is_entry = (node_r >= CODE_FIRST_ENTRY);
  assign node_bad_byte = (node_r < CODE_FIRST_BYTE);
  // a link to walk with no stack room left, or pointing outside the store
  assign walk_overflow = (depth_r >= DW'(STACK_DEPTH)) ||
                         (CW1'(node_r) >= CW1'(DICT_ENTRIES));
  assign can_add       = (prev_r != CODE_NONE) && !fill_full;
  assign total_inc     = (total_r == TOTAL_MAX) ? total_r : total_r + TOTAL_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !stopped_r && (in_chan.code != CODE_WIDTH_STEP)) begin
          if (in_chan.code < CODE_WIDTH_STEP) begin
            state_nxt = ST_ERROR;
          end else if (code_unknown && ((prev_r == CODE_NONE) || fill_full)) begin
            state_nxt = ST_ERROR;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (node_is_entry) begin
          state_nxt = walk_overflow ? ST_ERROR : ST_READ;
        end else begin
          state_nxt = node_bad_byte ? ST_ERROR : ST_EMIT_FIRST;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_EMIT_FIRST: begin
        if (out_free) begin
          state_nxt = (depth_r != DW'(0)) ? ST_EMIT_STACK : ST_IDLE;
        end
      end
      ST_EMIT_STACK: begin
        if (out_free && (idx_r == SW'(0))) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath, memory requests and output register
  always_comb begin
    stopped_nxt     = stopped_r;
    fill_nxt        = fill_r;
    prev_nxt        = prev_r;
    prev_first_nxt  = prev_first_r;
    total_nxt       = total_r;
    code_nxt        = code_r;
    unknown_nxt     = unknown_r;
    node_nxt        = node_r;
    depth_nxt       = depth_r;
    idx_nxt         = idx_r;
    first_nxt       = first_r;

    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;
    out_corrupt_nxt = out_corrupt_r;
    out_total_nxt   = out_total_r;

    dict_we      = 1'b0;
    dict_waddr   = fill_r[AW-1:0];
    dict_wprefix = prev_r[AW-1:0];
    dict_wsuffix = BYTE_W'(node_r - CODE_FIRST_BYTE);
    dict_re      = 1'b0;
    dict_raddr   = node_r[AW-1:0];

    stk_we    = 1'b0;
    stk_waddr = depth_r[SW-1:0];
    stk_wdata = dict_rsuffix;
    stk_re    = 1'b0;
    stk_raddr = SW'(depth_r - DW'(1));

    case (state_r)
      ST_IDLE: begin
        code_nxt    = in_chan.code;
        unknown_nxt = code_unknown;
        if (code_unknown) begin
          // KwKwK: previous string, then its own first byte at the very end
          node_nxt  = prev_r;
          depth_nxt = DW'(1);
          if (accept && !stopped_r && !fill_full && (prev_r != CODE_NONE)) begin
            stk_we    = 1'b1;
            stk_waddr = SW'(0);
            stk_wdata = prev_first_r;
          end
        end else begin
          node_nxt  = in_chan.code;
          depth_nxt = DW'(0);
        end
      end
      ST_CHECK: begin
        if (node_is_entry) begin
          dict_re = !walk_overflow;
        end else if (!node_bad_byte) begin
          // string resolved: record the new entry when one can be added, and advance the history
          first_nxt      = BYTE_W'(node_r - CODE_FIRST_BYTE);
          prev_first_nxt = BYTE_W'(node_r - CODE_FIRST_BYTE);
          prev_nxt       = code_r;
          if (can_add) begin
            dict_we  = 1'b1;
            fill_nxt = fill_r + FW'(1);
            if (unknown_r) begin
              prev_nxt = CODE_W'(fill_r);
            end
          end
        end
      end
      ST_READ: begin
        // push the suffix, follow the prefix link
        stk_we    = 1'b1;
        depth_nxt = depth_r + DW'(1);
        node_nxt  = CODE_W'(dict_rprefix);
      end
      ST_EMIT_FIRST: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = first_r;
          out_last_nxt    = (depth_r == DW'(0));
          out_corrupt_nxt = 1'b0;
          out_total_nxt   = total_inc;
          total_nxt       = total_inc;
          stk_re          = (depth_r != DW'(0));
          idx_nxt         = SW'(depth_r - DW'(1));
        end
      end
      ST_EMIT_STACK: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = stk_rdata;
          out_last_nxt    = (idx_r == SW'(0));
          out_corrupt_nxt = 1'b0;
          out_total_nxt   = total_inc;
          total_nxt       = total_inc;
          stk_raddr       = idx_r - SW'(1);
          stk_re          = (idx_r != SW'(0));
          idx_nxt         = idx_r - SW'(1);
        end
      end
      ST_ERROR: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = '0;
          out_last_nxt    = 1'b1;
          out_corrupt_nxt = 1'b1;
          out_total_nxt   = total_r;
          stopped_nxt     = 1'b1;
        end
      end
      default: begin
        stopped_nxt = stopped_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      stopped_r    <= 1'b0;
      fill_r       <= FW'(CODE_FIRST_ENTRY);
      prev_r       <= CODE_NONE;
      prev_first_r <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      stopped_r    <= stopped_nxt;
      fill_r       <= fill_nxt;
      prev_r       <= prev_nxt;
      prev_first_r <= prev_first_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    code_r        <= code_nxt;
    unknown_r     <= unknown_nxt;
    node_r        <= node_nxt;
    depth_r       <= depth_nxt;
    idx_r         <= idx_nxt;
    first_r       <= first_nxt;
    out_byte_r    <= out_byte_nxt;
    out_last_r    <= out_last_nxt;
    out_corrupt_r <= out_corrupt_nxt;
    out_total_r   <= out_total_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.last_of_run = out_last_r;
  assign out_chan.corrupt     = out_corrupt_r;
  assign out_chan.total_count = out_total_r;

endmodule
